// ----- hw/rtl/pservo_pkg.sv -----
// shared types, constants and codes of the position servo
// no dependencies; used by every module under hw/rtl
package pservo_pkg;

    // field widths
    localparam int READ_W    = 10;
    localparam int ANGLE_W   = 9;
    localparam int TOUT_W    = 15;
    localparam int POS_W     = 12;
    localparam int ELAPSED_W = 16;
    localparam int STILL_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;

    // map constants: reading window spans 358 degrees, offset by 1
    localparam int MAP_SPAN   = 358;
    localparam int MAP_OFFSET = 1;
    localparam int POS_MIN    = -1024;
    localparam int POS_MAX    = 2047;

    // serial divider: |num| is at most 1023 * 358, which fits in 19 bits
    localparam int DVD_W = 19;
    localparam int CNT_W = 5;
    localparam int QS_W  = DVD_W + 2;

    // supervision limits
    localparam int STALL_LIMIT  = 10;
    localparam int DEADBAND_DEG = 4;

    // stream packing
    localparam int IN_DATA_W  = 24;
    localparam int OUT_BITS   = 9 + POS_W + ELAPSED_W;
    localparam int OUT_DATA_W = 40;

    // reset values of the configuration registers
    localparam logic [READ_W-1:0]  RST_WIN_LOW  = 10'd406;
    localparam logic [READ_W-1:0]  RST_WIN_HIGH = 10'd617;
    localparam logic [TOUT_W-1:0]  RST_TIMEOUT  = 15'd300;
    localparam logic [ANGLE_W-1:0] RST_MIN_ANG  = 9'd1;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANG  = 9'd359;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIN_LOW  = 3'd0,
        REG_WIN_HIGH = 3'd1,
        REG_TIMEOUT  = 3'd2,
        REG_MIN_ANG  = 3'd3,
        REG_MAX_ANG  = 3'd4
    } cfg_reg_t;

    // item opcodes
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POS,
        ST_COMMIT
    } ps_state_t;

    typedef struct packed {
        logic [READ_W-1:0]  win_low;
        logic [READ_W-1:0]  win_high;
        logic [TOUT_W-1:0]  timeout;
        logic [ANGLE_W-1:0] min_ang;
        logic [ANGLE_W-1:0] max_ang;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture a beat and set up the divider
        logic step;    // one divider iteration
        logic pos;     // form the saturated position
        logic commit;  // update trim state and the result register
    } ps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;  // final divider iteration this cycle
    } ps_stat_t;

endpackage

// ----- hw/rtl/pservo_ctrl.sv -----
// controller of the position servo: sequencing and result handshake
// depends on pservo_pkg
module pservo_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pservo_pkg::ps_cmd_t  cmd,
    input  pservo_pkg::ps_stat_t stat
);

    pservo_pkg::ps_state_t state_reg;
    pservo_pkg::ps_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pservo_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pservo_pkg::ST_DIV;
                end
            end
            pservo_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = pservo_pkg::ST_POS;
                end
            end
            pservo_pkg::ST_POS:
            begin
                state_next = pservo_pkg::ST_COMMIT;
            end
            pservo_pkg::ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = pservo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pservo_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            pservo_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pservo_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            pservo_pkg::ST_POS:
            begin
                cmd.pos = 1'b1;
            end
            pservo_pkg::ST_COMMIT:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pservo_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/pservo_dp.sv -----
// datapath of the position servo: reading map with serial divider,
// trim supervision state and result register; depends on pservo_pkg
module pservo_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pservo_pkg::cfg_t                      cfg,
    input  pservo_pkg::ps_cmd_t                   cmd,
    output pservo_pkg::ps_stat_t                  stat,
    input  logic                                  in_opcode,
    input  logic [pservo_pkg::ANGLE_W-1:0]        in_target,
    input  logic [pservo_pkg::READ_W-1:0]         in_reading,
    output logic [pservo_pkg::OUT_BITS-1:0]       result
);

    localparam int RW = pservo_pkg::READ_W;
    localparam int AW = pservo_pkg::ANGLE_W;
    localparam int PW = pservo_pkg::POS_W;
    localparam int EW = pservo_pkg::ELAPSED_W;
    localparam int SW = pservo_pkg::STILL_W;
    localparam int DW = pservo_pkg::DVD_W;
    localparam int CW = pservo_pkg::CNT_W;
    localparam int QW = pservo_pkg::QS_W;

    localparam logic signed [QW-1:0] SAT_LO = QW'(pservo_pkg::POS_MIN);
    localparam logic signed [QW-1:0] SAT_HI = QW'(pservo_pkg::POS_MAX);
    localparam logic signed [PW:0]   DB_POS = (PW+1)'(pservo_pkg::DEADBAND_DEG);
    localparam logic signed [PW:0]   DB_NEG = -(PW+1)'(pservo_pkg::DEADBAND_DEG);

    // captured beat
    logic          op_reg;
    logic [AW-1:0] tgt_in_reg;

    // divider
    logic [DW-1:0] rq_reg;
    logic [DW-1:0] rq_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] den_mag_reg;
    logic          den_zero_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [PW-1:0] pos_reg;

    // trim state
    logic          trimming_reg;
    logic [AW-1:0] target_reg;
    logic [PW-1:0] last_pos_reg;
    logic [SW-1:0] still_reg;
    logic [EW-1:0] elapsed_reg;
    logic          stall_reg;
    logic          timeout_reg;
    logic [pservo_pkg::OUT_BITS-1:0] result_reg;

    // load-time map front end
    logic signed [RW:0]   num_diff;
    logic signed [RW:0]   den_diff;
    logic [RW-1:0]        num_abs;
    logic [DW-1:0]        num_mag;

    assign num_diff = $signed({1'b0, in_reading}) - $signed({1'b0, cfg.win_low});
    assign den_diff = $signed({1'b0, cfg.win_high}) - $signed({1'b0, cfg.win_low});
    assign num_abs  = num_diff[RW] ? RW'(-num_diff) : num_diff[RW-1:0];
    assign num_mag  = DW'(num_abs) * DW'(pservo_pkg::MAP_SPAN);

    // restoring divider step
    logic [RW:0] shifted;
    logic        ge;
    logic [RW:0] diff_rem;

    assign shifted  = {rem_reg, rq_reg[DW-1]};
    assign ge       = shifted >= {1'b0, den_mag_reg};
    assign diff_rem = shifted - {1'b0, den_mag_reg};
    assign rem_next = ge ? diff_rem[RW-1:0] : shifted[RW-1:0];
    assign rq_next  = {rq_reg[DW-2:0], ge};

    assign stat.div_last = cmd.step && (cnt_reg == '0);

    // quotient to saturated position
    logic signed [QW-1:0] q_signed;
    logic signed [QW-1:0] p_full;
    logic signed [PW-1:0] pos_val;

    assign q_signed = neg_reg ? -$signed({2'b00, rq_reg}) : $signed({2'b00, rq_reg});
    assign p_full   = q_signed + QW'(pservo_pkg::MAP_OFFSET);

    always_comb
    begin
        if (den_zero_reg)
        begin
            pos_val = PW'(pservo_pkg::MAP_OFFSET);
        end
        else if (p_full < SAT_LO)
        begin
            pos_val = SAT_LO[PW-1:0];
        end
        else if (p_full > SAT_HI)
        begin
            pos_val = SAT_HI[PW-1:0];
        end
        else
        begin
            pos_val = p_full[PW-1:0];
        end
    end

    // commit logic
    logic          trimming_next;
    logic [AW-1:0] target_next;
    logic [PW-1:0] last_pos_next;
    logic [SW-1:0] still_next;
    logic [EW-1:0] elapsed_next;
    logic          stall_next;
    logic          timeout_next;
    logic          finished;
    logic          valid_order;
    logic signed [PW:0] pos_ext;
    logic signed [PW:0] tgt_ext;
    logic signed [PW:0] err;
    logic [AW-1:0] chk_tgt;
    logic          stop;

    assign pos_ext = {pos_reg[PW-1], pos_reg};
    assign chk_tgt = (op_reg == pservo_pkg::OP_START) ? tgt_in_reg : target_reg;
    assign valid_order = (chk_tgt >= cfg.min_ang) && (chk_tgt <= cfg.max_ang);

    always_comb
    begin
        trimming_next = trimming_reg;
        target_next   = target_reg;
        last_pos_next = last_pos_reg;
        still_next    = still_reg;
        elapsed_next  = elapsed_reg;
        stall_next    = stall_reg;
        timeout_next  = timeout_reg;
        finished      = 1'b0;
        stop          = 1'b0;
        tgt_ext       = $signed({4'b0000, tgt_in_reg});
        err           = pos_ext - tgt_ext;
        if (op_reg == pservo_pkg::OP_START)
        begin
            target_next   = tgt_in_reg;
            elapsed_next  = '0;
            still_next    = '0;
            stall_next    = 1'b0;
            timeout_next  = 1'b0;
            last_pos_next = pos_reg;
            if ((err > DB_POS) || (err < DB_NEG))
            begin
                trimming_next = 1'b1;
            end
            else
            begin
                trimming_next = 1'b0;
                finished      = 1'b1;
            end
        end
        else if (trimming_reg)
        begin
            if (elapsed_reg != '1)
            begin
                elapsed_next = elapsed_reg + 1'b1;
            end
            if (elapsed_next > {1'b0, cfg.timeout})
            begin
                stop         = 1'b1;
                timeout_next = 1'b1;
            end
            if (pos_reg == last_pos_reg)
            begin
                if (still_reg != '1)
                begin
                    still_next = still_reg + 1'b1;
                end
                if (still_next > SW'(pservo_pkg::STALL_LIMIT))
                begin
                    stop       = 1'b1;
                    stall_next = 1'b1;
                end
            end
            else
            begin
                last_pos_next = pos_reg;
                still_next    = '0;
                stall_next    = 1'b0;
            end
            if (pos_ext == $signed({4'b0000, target_reg}))
            begin
                stop = 1'b1;
            end
            if (stop)
            begin
                trimming_next = 1'b0;
                finished      = 1'b1;
            end
        end
    end

    // result fields, highest bit first
    logic [pservo_pkg::OUT_BITS-1:0] result_next;
    logic signed [PW:0] tnew_ext;

    assign tnew_ext = $signed({4'b0000, target_next});
    assign result_next = {
        elapsed_next,
        pos_reg,
        valid_order,
        timeout_next,
        stall_next,
        finished && !stall_next && !timeout_next,
        finished,
        trimming_next,
        trimming_next,
        trimming_next && (pos_ext < tnew_ext),
        trimming_next && (pos_ext > tnew_ext)
    };

    assign result = result_reg;

    // payload, divider, position and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_opcode;
            tgt_in_reg   <= in_target;
            rq_reg       <= num_mag;
            rem_reg      <= '0;
            den_mag_reg  <= den_diff[RW] ? RW'(-den_diff) : den_diff[RW-1:0];
            den_zero_reg <= (den_diff == '0);
            neg_reg      <= num_diff[RW] ^ den_diff[RW];
            cnt_reg      <= CW'(DW - 1);
        end
        else if (cmd.step)
        begin
            rq_reg  <= rq_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.pos)
        begin
            pos_reg <= pos_val;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    // trim state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trimming_reg <= 1'b0;
            target_reg   <= '0;
            last_pos_reg <= '0;
            still_reg    <= '0;
            elapsed_reg  <= '0;
            stall_reg    <= 1'b0;
            timeout_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            trimming_reg <= trimming_next;
            target_reg   <= target_next;
            last_pos_reg <= last_pos_next;
            still_reg    <= still_next;
            elapsed_reg  <= elapsed_next;
            stall_reg    <= stall_next;
            timeout_reg  <= timeout_next;
        end
    end

endmodule

// ----- hw/rtl/position_servo_with_stall_timeout.sv -----
// top level of the bang-bang position servo with stall and timeout supervision
// holds the configuration registers; depends on pservo_pkg, pservo_ctrl, pservo_dp
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------------
//  s_*      | in        | tuser: opcode; tdata: target_angle, pot_reading
//  m_*      | out       | tdata: drive and status bits, position_degrees, elapsed
//  cfg_*    | in        | write enable, register index, data (no read-back)
//
// each input beat runs in order: the accepting cycle loads the divider,
// 19 iterations of the restoring divider in the reading map follow, then the
// position state forms the saturated position and the commit state commits it.
// m_tvalid comes from a register that the commit sets.
// s_tready is high only while no beat is in work; a waiting result sits in
// the output register, so the next beat is taken before m_tready comes back.
// a stalled m_tready holds the commit cycle and the trim state unchanged.
// rst_n clears the trim state and loads the configuration defaults.
module position_servo_with_stall_timeout
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 s_tuser,   // [0] opcode
    input  logic [pservo_pkg::IN_DATA_W-1:0]     s_tdata,   // [8:0] target_angle,
                                                            // [18:9] pot_reading

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pservo_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] drive_down,
                                                            // [1] drive_up,
                                                            // [2] motor_on,
                                                            // [3] busy_res,
                                                            // [4] finished,
                                                            // [5] success,
                                                            // [6] stalled,
                                                            // [7] timed_out,
                                                            // [8] order_in_range,
                                                            // [20:9] position_degrees,
                                                            // [36:21] elapsed_seconds

    input  logic                                 cfg_we,
    input  logic [pservo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pservo_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int RW = pservo_pkg::READ_W;
    localparam int AW = pservo_pkg::ANGLE_W;

    // configuration registers
    pservo_pkg::cfg_t cfg_reg;
    pservo_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pservo_pkg::REG_WIN_LOW:  cfg_next.win_low  = cfg_data[RW-1:0];
                pservo_pkg::REG_WIN_HIGH: cfg_next.win_high = cfg_data[RW-1:0];
                pservo_pkg::REG_TIMEOUT:  cfg_next.timeout  = cfg_data;
                pservo_pkg::REG_MIN_ANG:  cfg_next.min_ang  = cfg_data[AW-1:0];
                pservo_pkg::REG_MAX_ANG:  cfg_next.max_ang  = cfg_data[AW-1:0];
                default:                  cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_low  <= pservo_pkg::RST_WIN_LOW;
            cfg_reg.win_high <= pservo_pkg::RST_WIN_HIGH;
            cfg_reg.timeout  <= pservo_pkg::RST_TIMEOUT;
            cfg_reg.min_ang  <= pservo_pkg::RST_MIN_ANG;
            cfg_reg.max_ang  <= pservo_pkg::RST_MAX_ANG;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // controller and datapath
    pservo_pkg::ps_cmd_t  cmd;
    pservo_pkg::ps_stat_t stat;
    logic [pservo_pkg::OUT_BITS-1:0] result;

    pservo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pservo_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (s_tuser),
        .in_target  (s_tdata[AW-1:0]),
        .in_reading (s_tdata[AW+RW-1:AW]),
        .result     (result)
    );

    // pad the result beat to whole bytes
    assign m_tdata = {{(pservo_pkg::OUT_DATA_W - pservo_pkg::OUT_BITS){1'b0}}, result};

endmodule
